/* design/cfns_pkg.sv */
`default_nettype none
package cfns_pkg;

    localparam int SRC_W          = 16;
    localparam int FRM_W          = 12;
    localparam int PROD_W         = SRC_W + FRM_W;
    localparam int DIV_NUM_W      = 30;
    localparam int DIV_DEN_W      = SRC_W;
    localparam int CFG_IDX_W      = 2;
    localparam int RGB_W          = 16;
    localparam int MAX_REPEAT_DEF = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_COLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_ROWS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 2'd3;

    localparam logic [1:0] SPAN_COL_LO = 2'd0;
    localparam logic [1:0] SPAN_COL_HI = 2'd1;
    localparam logic [1:0] SPAN_ROW_LO = 2'd2;
    localparam logic [1:0] SPAN_ROW_HI = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FIT_MUL,
        ST_FIT_DIV,
        ST_FIT_WAIT,
        ST_FIT_SET,
        ST_PIX_MUL,
        ST_SPAN_DIV,
        ST_SPAN_WAIT,
        ST_SPAN_CHK,
        ST_EMIT
    } cfns_state_t;

    typedef struct packed {
        logic load;
        logic fit_mul;
        logic div_start;
        logic fit_set;
        logic pix_mul;
        logic span_store;
        logic span_chk;
        logic step;
    } cfns_cmd_t;

    typedef struct packed {
        logic div_busy;
        logic last_span;
        logic empty;
        logic last_out;
    } cfns_status_t;

    function automatic logic [RGB_W-1:0] pack_rgb565(input logic [7:0] r,
                                                     input logic [7:0] g,
                                                     input logic [7:0] b);
        pack_rgb565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage
`default_nettype wire

/* design/cfns_div.sv */
`default_nettype none
module cfns_div
    import cfns_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [DIV_NUM_W-1:0] num,
    input  wire logic [DIV_DEN_W-1:0] den,
    output logic                      busy,
    output logic [DIV_NUM_W-1:0]      quot
);

    // radix-4: two restoring steps per cycle
    localparam int STEPS = DIV_NUM_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic [DIV_DEN_W-1:0] den_reg;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 busy_reg;

    always_comb begin
        logic [DIV_DEN_W:0]   trial;
        logic [DIV_DEN_W-1:0] r;
        logic [DIV_NUM_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int k = 0; k < 2; k++) begin
            trial = {r, q[DIV_NUM_W-1]};
            q = {q[DIV_NUM_W-2:0], 1'b0};
            if (trial >= {1'b0, den_reg}) begin
                trial = trial - {1'b0, den_reg};
                q[0] = 1'b1;
            end
            r = trial[DIV_DEN_W-1:0];
        end
        rem_next = r;
        quo_next = q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(STEPS);
        end else if (busy_reg) begin
            cnt_reg  <= cnt_reg - CNT_W'(1);
            busy_reg <= (cnt_reg != CNT_W'(1));
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            den_reg <= den;
            rem_reg <= '0;
            quo_reg <= num;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    assign busy = busy_reg;
    assign quot = quo_reg;

endmodule
`default_nettype wire

/* design/cfns_dp.sv */
`default_nettype none
module cfns_dp
    import cfns_pkg::*;
#(
    parameter int MAX_REPEAT = MAX_REPEAT_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SRC_W-1:0]     cfg_data,
    input  wire logic                 s_mode,
    input  wire logic [SRC_W-1:0]     s_pix_col,
    input  wire logic [SRC_W-1:0]     s_pix_row,
    input  wire logic [7:0]           s_blue_in,
    input  wire logic [7:0]           s_green_in,
    input  wire logic [7:0]           s_red_in,
    input  wire cfns_cmd_t            cmd,
    output cfns_status_t              status,
    output logic [FRM_W-1:0]          m_dest_col,
    output logic [FRM_W-1:0]          m_dest_row,
    output logic [RGB_W-1:0]          m_rgb565_out,
    output logic                      m_last_of_run,
    output logic                      m_clipped
);

    localparam int RUN_W = $clog2(MAX_REPEAT + 1);

    logic [SRC_W-1:0] src_cols_reg, src_rows_reg;
    logic [FRM_W-1:0] frame_cols_reg, frame_rows_reg;
    logic [FRM_W-1:0] fit_cols_reg, fit_rows_reg, pad_left_reg, pad_top_reg;

    logic [SRC_W-1:0] pix_col_reg, pix_row_reg;
    logic [RGB_W-1:0] color_reg;
    logic [PROD_W-1:0] prod_a_reg, prod_b_reg;
    logic              ge_reg;
    logic              pix_mode_reg;
    logic [1:0]        span_sel_reg;
    logic [DIV_NUM_W-1:0] x0_reg, x1_reg, y0_reg, y1_reg;
    logic [FRM_W-1:0]  x0_out_reg, y0_out_reg;
    logic [RUN_W-1:0]  nx_reg, ny_reg, i_reg, j_reg;
    logic              cut_reg;

    logic [SRC_W-1:0] sc, sr;
    logic [FRM_W-1:0] fc, fr;
    logic [DIV_NUM_W-1:0] div_num;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_busy;
    logic [DIV_NUM_W-1:0] div_quot;

    // zero-valued size registers act as 1
    assign sc = (src_cols_reg == '0)   ? SRC_W'(1) : src_cols_reg;
    assign sr = (src_rows_reg == '0)   ? SRC_W'(1) : src_rows_reg;
    assign fc = (frame_cols_reg == '0) ? FRM_W'(1) : frame_cols_reg;
    assign fr = (frame_rows_reg == '0) ? FRM_W'(1) : frame_rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_cols_reg   <= SRC_W'(1);
            src_rows_reg   <= SRC_W'(1);
            frame_cols_reg <= FRM_W'(1);
            frame_rows_reg <= FRM_W'(1);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SRC_COLS:   src_cols_reg   <= cfg_data;
                REG_SRC_ROWS:   src_rows_reg   <= cfg_data;
                REG_FRAME_COLS: frame_cols_reg <= cfg_data[FRM_W-1:0];
                REG_FRAME_ROWS: frame_rows_reg <= cfg_data[FRM_W-1:0];
                default: ;
            endcase
        end
    end

    // divider operand select
    always_comb begin
        logic [DIV_NUM_W-1:0] sc_m1, sr_m1;
        sc_m1 = DIV_NUM_W'(sc) - DIV_NUM_W'(1);
        sr_m1 = DIV_NUM_W'(sr) - DIV_NUM_W'(1);
        div_num = '0;
        div_den = sc;
        if (!pix_mode_reg) begin
            div_num = (prod_a_reg >= prod_b_reg) ? DIV_NUM_W'(prod_b_reg)
                                                 : DIV_NUM_W'(prod_a_reg);
            div_den = (prod_a_reg >= prod_b_reg) ? sc : sr;
        end else begin
            case (span_sel_reg)
                SPAN_COL_LO: begin
                    div_num = DIV_NUM_W'(prod_a_reg) + sc_m1;
                    div_den = sc;
                end
                SPAN_COL_HI: begin
                    div_num = DIV_NUM_W'(prod_a_reg) + DIV_NUM_W'(fit_cols_reg) + sc_m1;
                    div_den = sc;
                end
                SPAN_ROW_LO: begin
                    div_num = DIV_NUM_W'(prod_b_reg) + sr_m1;
                    div_den = sr;
                end
                default: begin
                    div_num = DIV_NUM_W'(prod_b_reg) + DIV_NUM_W'(fit_rows_reg) + sr_m1;
                    div_den = sr;
                end
            endcase
        end
    end

    cfns_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quot    (div_quot)
    );

    // clamp upper bounds to the fit size, then count run lengths
    logic [DIV_NUM_W-1:0] x1c, y1c, nx_full, ny_full;
    logic                 x_empty, y_empty;
    logic [RUN_W-1:0]     nx_cl, ny_cl;
    logic                 cut_now;

    always_comb begin
        x1c = (x1_reg > DIV_NUM_W'(fit_cols_reg)) ? DIV_NUM_W'(fit_cols_reg) : x1_reg;
        y1c = (y1_reg > DIV_NUM_W'(fit_rows_reg)) ? DIV_NUM_W'(fit_rows_reg) : y1_reg;
        x_empty = (x1c <= x0_reg);
        y_empty = (y1c <= y0_reg);
        nx_full = x1c - x0_reg;
        ny_full = y1c - y0_reg;
        cut_now = 1'b0;
        nx_cl = nx_full[RUN_W-1:0];
        ny_cl = ny_full[RUN_W-1:0];
        if (nx_full > DIV_NUM_W'(MAX_REPEAT)) begin
            nx_cl   = RUN_W'(MAX_REPEAT);
            cut_now = 1'b1;
        end
        if (ny_full > DIV_NUM_W'(MAX_REPEAT)) begin
            ny_cl   = RUN_W'(MAX_REPEAT);
            cut_now = 1'b1;
        end
    end

    logic i_last, j_last;
    assign i_last = (i_reg == nx_reg - RUN_W'(1));
    assign j_last = (j_reg == ny_reg - RUN_W'(1));

    // fit size result
    logic [FRM_W-1:0] q12, w_new, h_new;
    always_comb begin
        q12   = div_quot[FRM_W-1:0];
        w_new = ge_reg ? fc : q12;
        h_new = ge_reg ? q12 : fr;
        if (w_new == '0) w_new = FRM_W'(1);
        if (h_new == '0) h_new = FRM_W'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fit_cols_reg <= FRM_W'(1);
            fit_rows_reg <= FRM_W'(1);
            pad_left_reg <= '0;
            pad_top_reg  <= '0;
            span_sel_reg <= SPAN_COL_LO;
            pix_mode_reg <= 1'b0;
        end else begin
            if (cmd.load) pix_mode_reg <= s_mode;
            if (cmd.fit_set) begin
                fit_cols_reg <= w_new;
                fit_rows_reg <= h_new;
                pad_left_reg <= (fc - w_new) >> 1;
                pad_top_reg  <= (fr - h_new) >> 1;
            end
            if (cmd.pix_mul) span_sel_reg <= SPAN_COL_LO;
            else if (cmd.span_store) span_sel_reg <= span_sel_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            pix_col_reg <= s_pix_col;
            pix_row_reg <= s_pix_row;
            color_reg   <= pack_rgb565(s_red_in, s_green_in, s_blue_in);
        end
        if (cmd.fit_mul) begin
            prod_a_reg <= PROD_W'(sc) * PROD_W'(fr);
            prod_b_reg <= PROD_W'(sr) * PROD_W'(fc);
        end
        if (cmd.pix_mul) begin
            prod_a_reg <= PROD_W'(pix_col_reg) * PROD_W'(fit_cols_reg);
            prod_b_reg <= PROD_W'(pix_row_reg) * PROD_W'(fit_rows_reg);
        end
        if (cmd.div_start) ge_reg <= (prod_a_reg >= prod_b_reg);
        if (cmd.span_store) begin
            case (span_sel_reg)
                SPAN_COL_LO: x0_reg <= div_quot;
                SPAN_COL_HI: x1_reg <= div_quot;
                SPAN_ROW_LO: y0_reg <= div_quot;
                default:     y1_reg <= div_quot;
            endcase
        end
        if (cmd.span_chk) begin
            nx_reg     <= nx_cl;
            ny_reg     <= ny_cl;
            cut_reg    <= cut_now;
            x0_out_reg <= x0_reg[FRM_W-1:0] + pad_left_reg;
            y0_out_reg <= y0_reg[FRM_W-1:0] + pad_top_reg;
            i_reg      <= '0;
            j_reg      <= '0;
        end else if (cmd.step) begin
            if (i_last) begin
                i_reg <= '0;
                j_reg <= j_reg + RUN_W'(1);
            end else begin
                i_reg <= i_reg + RUN_W'(1);
            end
        end
    end

    assign status.div_busy  = div_busy;
    assign status.last_span = (span_sel_reg == SPAN_ROW_HI);
    assign status.empty     = x_empty | y_empty;
    assign status.last_out  = i_last & j_last;

    assign m_dest_col    = x0_out_reg + FRM_W'(i_reg);
    assign m_dest_row    = y0_out_reg + FRM_W'(j_reg);
    assign m_rgb565_out  = color_reg;
    assign m_last_of_run = i_last & j_last;
    assign m_clipped     = cut_reg;

endmodule
`default_nettype wire

/* design/cfns_ctrl.sv */
`default_nettype none
module cfns_ctrl
    import cfns_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    input  wire logic         s_mode,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire cfns_status_t status,
    output cfns_cmd_t         cmd
);

    cfns_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = s_mode ? ST_PIX_MUL : ST_FIT_MUL;
                end
            end
            ST_FIT_MUL: begin
                cmd.fit_mul = 1'b1;
                state_next  = ST_FIT_DIV;
            end
            ST_FIT_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_FIT_WAIT;
            end
            ST_FIT_WAIT: begin
                if (!status.div_busy) state_next = ST_FIT_SET;
            end
            ST_FIT_SET: begin
                cmd.fit_set = 1'b1;
                state_next  = ST_IDLE;
            end
            ST_PIX_MUL: begin
                cmd.pix_mul = 1'b1;
                state_next  = ST_SPAN_DIV;
            end
            ST_SPAN_DIV: begin
                cmd.div_start = 1'b1;
                state_next    = ST_SPAN_WAIT;
            end
            ST_SPAN_WAIT: begin
                if (!status.div_busy) begin
                    cmd.span_store = 1'b1;
                    state_next     = status.last_span ? ST_SPAN_CHK : ST_SPAN_DIV;
                end
            end
            ST_SPAN_CHK: begin
                if (status.empty) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.span_chk = 1'b1;
                    state_next   = ST_EMIT;
                end
            end
            ST_EMIT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    cmd.step = 1'b1;
                    if (status.last_out) state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule
`default_nettype wire

/* design/contain_fit_nearest_scaler.sv */
`default_nettype none
// A start request (s_mode low) gives no result. A pixel request runs four passes of the
// shared radix-4 divider before its first result, then gives one
// result per cycle while m_ready is high, up to MAX_REPEAT squared results.
// One request in flight at a time.
// Reset (aresetn low, synchronous): idle, size registers 1, fit 1x1, pads 0.
module contain_fit_nearest_scaler
    import cfns_pkg::*;
#(
    parameter int MAX_REPEAT = MAX_REPEAT_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    // configuration writes
    input  wire logic                 cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [SRC_W-1:0]     cfg_data,
    // request channel
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic                 s_mode,
    input  wire logic [SRC_W-1:0]     s_pix_col,
    input  wire logic [SRC_W-1:0]     s_pix_row,
    input  wire logic [7:0]           s_blue_in,
    input  wire logic [7:0]           s_green_in,
    input  wire logic [7:0]           s_red_in,
    // result channel
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [FRM_W-1:0]          m_dest_col,
    output logic [FRM_W-1:0]          m_dest_row,
    output logic [RGB_W-1:0]          m_rgb565_out,
    output logic                      m_last_of_run,
    output logic                      m_clipped
);

    cfns_cmd_t    cmd;
    cfns_status_t status;

    // sequencer: accept, multiply, divide passes, emit loop
    cfns_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_mode  (s_mode),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // config, fit/pad state, span math and output counters
    cfns_dp #(
        .MAX_REPEAT (MAX_REPEAT)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_mode        (s_mode),
        .s_pix_col     (s_pix_col),
        .s_pix_row     (s_pix_row),
        .s_blue_in     (s_blue_in),
        .s_green_in    (s_green_in),
        .s_red_in      (s_red_in),
        .cmd           (cmd),
        .status        (status),
        .m_dest_col    (m_dest_col),
        .m_dest_row    (m_dest_row),
        .m_rgb565_out  (m_rgb565_out),
        .m_last_of_run (m_last_of_run),
        .m_clipped     (m_clipped)
    );

    // never take a request while results are pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("request accepted during result output");

    // after an accepted request the block is not ready in the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("ready not dropped after request");

    // final result of a run closes the output
    a_last_closes: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && m_last_of_run) |=> !m_valid)
        else $error("result after last_of_run");

    // clip flag is constant over one run
    a_clip_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !m_last_of_run) |=> (m_valid && m_clipped == $past(m_clipped)))
        else $error("clipped changed within a run");

endmodule
`default_nettype wire
